FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("check failed");
// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

FILE: rtl/core/mtnt_pkg.sv
// ----------------------------------------------------------------------------
// mtnt_pkg
// Types and codes shared by the note timer controller and datapath.
// ----------------------------------------------------------------------------
package mtnt_pkg;
	localparam logic [1:0] KIND_NOTE   = 2'd0;
	localparam logic [1:0] KIND_NO_RS  = 2'd1;
	localparam logic [1:0] KIND_BAD_ST = 2'd2;
	localparam logic [1:0] KIND_OVFL   = 2'd3;
	localparam int MAX_OUT = 16;

	typedef struct packed {
		logic        clear;
		logic        note_on;
		logic        note_off;
		logic        scan;
		logic        err;
		logic [1:0]  err_kind;
		logic [3:0]  ch;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [27:0] delta;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_full;
	} stat_t;
endpackage

FILE: rtl/core/midi_track_note_timer_top.sv
// ----------------------------------------------------------------------------
// midi_track_note_timer_top
// Standard MIDI file byte parser that times held notes and emits records.
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// input     in   in_valid/in_ready    file_byte
// output    out  out_valid/out_ready  record_kind .. last_of_run
//
// A byte may yield an output beat. A delta end scans the note table one
// entry per cycle, unless a finished note meets a pending record while the
// output is full; the scan may flush a last record at its end.
// Input holds off while a result beat waits or a scan is running.
// Reset is asynchronous, active low.
module midi_track_note_timer_top #(
	parameter int NOTE_SLOTS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  file_byte,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic [3:0]  channel,
	output logic [6:0]  note_number,
	output logic [31:0] step_time,
	output logic [31:0] gate_time,
	output logic [6:0]  velocity,
	output logic        last_of_run
);
	// commands flow parser -> table, status flows back
	mtnt_pkg::cmd_t  cmd;
	mtnt_pkg::stat_t stat;

	mtnt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .file_byte(file_byte), .in_valid(in_valid),
		.in_ready(in_ready), .stat(stat), .cmd(cmd)
	);

	mtnt_dpath #(.NOTE_SLOTS(NOTE_SLOTS), .TIME_BITS(TIME_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.out_valid(out_valid), .out_ready(out_ready), .record_kind(record_kind),
		.channel(channel), .note_number(note_number), .step_time(step_time),
		.gate_time(gate_time), .velocity(velocity), .last_of_run(last_of_run)
	);
endmodule

FILE: rtl/core/mtnt_ctrl.sv
// ----------------------------------------------------------------------------
// mtnt_ctrl
// Byte parser and sequencer; issues table commands to the datapath.
// ----------------------------------------------------------------------------
module mtnt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        file_byte,
	input  logic              in_valid,
	output logic              in_ready,
	input  mtnt_pkg::stat_t   stat,
	output mtnt_pkg::cmd_t    cmd
);
	localparam logic [3:0] PH_HDR = 4'd0, PH_TRK = 4'd1, PH_DELTA = 4'd2,
		PH_EVENT = 4'd3, PH_DATA1 = 4'd4, PH_DATA2 = 4'd5, PH_SYSLEN = 4'd6,
		PH_MTYPE = 4'd7, PH_MLEN = 4'd8, PH_SKIP = 4'd9;
	localparam logic ST_IDLE = 1'b0, ST_SCAN = 1'b1;

	logic        st_q, st_d;
	logic [3:0]  ph_q, ph_d;
	logic [27:0] cnt_q, cnt_d, acc_q, acc_d, acc_nx;
	logic [7:0]  rs_q, rs_d;
	logic [6:0]  fd_q, fd_d;
	logic        halt_q, halt_d, acc_en;
	logic [3:0]  hi;

	assign in_ready = (st_q == ST_IDLE) && !stat.busy && !stat.out_full;
	assign acc_en = in_valid && in_ready && !halt_q;
	assign acc_nx = {acc_q[20:0], file_byte[6:0]};
	assign hi = rs_q[7:4];

	always_comb begin
		st_d = st_q; ph_d = ph_q; cnt_d = cnt_q; acc_d = acc_q;
		rs_d = rs_q; fd_d = fd_q; halt_d = halt_q;
		cmd = '0;
		cmd.ch = rs_q[3:0];
		cmd.note = fd_q;
		cmd.vel = file_byte[6:0];
		cmd.delta = acc_nx;
		if (st_q == ST_SCAN) begin
			if (!stat.busy) st_d = ST_IDLE;
		end else if (acc_en) begin
			unique case (ph_q)
				PH_HDR: begin
					if (cnt_q <= 28'd1) begin
						ph_d = PH_TRK; cnt_d = 28'd8; cmd.clear = 1'b1;
					end else cnt_d = cnt_q - 28'd1;
				end
				PH_TRK: begin
					if (cnt_q <= 28'd1) begin
						ph_d = PH_DELTA; acc_d = '0;
					end else cnt_d = cnt_q - 28'd1;
				end
				PH_EVENT: begin
					if (file_byte[7]) begin
						if (file_byte <= 8'hEF) begin
							rs_d = file_byte; ph_d = PH_DATA1;
						end else if (file_byte == 8'hFF) begin
							rs_d = '0; ph_d = PH_MTYPE;
						end else if (file_byte == 8'hF0 || file_byte == 8'hF7) begin
							rs_d = '0; acc_d = '0; ph_d = PH_SYSLEN;
						end else begin
							cmd.err = 1'b1; cmd.err_kind = mtnt_pkg::KIND_BAD_ST;
							halt_d = 1'b1;
						end
					end else if (rs_q == 8'h00) begin
						cmd.err = 1'b1; cmd.err_kind = mtnt_pkg::KIND_NO_RS;
						halt_d = 1'b1;
					end else begin
						fd_d = file_byte[6:0];
						ph_d = (hi == 4'hC || hi == 4'hD) ? PH_DELTA : PH_DATA2;
					end
				end
				PH_DATA1: begin
					fd_d = file_byte[6:0];
					ph_d = (hi == 4'hC || hi == 4'hD) ? PH_DELTA : PH_DATA2;
				end
				PH_DATA2: begin
					ph_d = PH_DELTA;
					if (hi == 4'h9 && file_byte[6:0] != 7'd0) cmd.note_on = 1'b1;
					else if (hi == 4'h9 || hi == 4'h8) cmd.note_off = 1'b1;
				end
				PH_SYSLEN, PH_MLEN: begin
					acc_d = acc_nx;
					if (!file_byte[7]) begin
						acc_d = '0;
						if (ph_q == PH_MLEN && fd_q == 7'd1 && acc_nx == 28'd0) begin
							cmd.clear = 1'b1; cnt_d = 28'd8; ph_d = PH_TRK;
						end else if (acc_nx == 28'd0) ph_d = PH_DELTA;
						else begin
							cnt_d = acc_nx; ph_d = PH_SKIP;
						end
					end
				end
				PH_MTYPE: begin
					fd_d = (file_byte == 8'h2F) ? 7'd1 : 7'd0;
					acc_d = '0; ph_d = PH_MLEN;
				end
				PH_SKIP: begin
					if (cnt_q <= 28'd1) ph_d = PH_DELTA;
					else cnt_d = cnt_q - 28'd1;
				end
				default: begin
					acc_d = acc_nx;
					ph_d = PH_DELTA;
					if (!file_byte[7]) begin
						acc_d = '0; ph_d = PH_EVENT;
						cmd.scan = 1'b1; st_d = ST_SCAN;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ph_q <= PH_HDR; cnt_q <= 28'd14; acc_q <= '0;
			rs_q <= '0; fd_q <= '0; halt_q <= 1'b0;
		end else begin
			st_q <= st_d; ph_q <= ph_d; cnt_q <= cnt_d; acc_q <= acc_d;
			rs_q <= rs_d; fd_q <= fd_d; halt_q <= halt_d;
		end
	end
endmodule

FILE: rtl/core/mtnt_dpath.sv
// ----------------------------------------------------------------------------
// mtnt_dpath
// Held-note table, stallable one-entry-per-cycle compaction scan, output reg.
// ----------------------------------------------------------------------------
module mtnt_dpath #(
	parameter int NOTE_SLOTS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mtnt_pkg::cmd_t   cmd,
	output mtnt_pkg::stat_t  stat,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       record_kind,
	output logic [3:0]       channel,
	output logic [6:0]       note_number,
	output logic [31:0]      step_time,
	output logic [31:0]      gate_time,
	output logic [6:0]       velocity,
	output logic             last_of_run
);
	localparam int CW = $clog2(NOTE_SLOTS + 1);
	localparam int IW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
	localparam int SW = ((TIME_BITS > 28) ? TIME_BITS : 28) + 1;
	localparam logic [SW-1:0] LIM = SW'((64'd1 << TIME_BITS) - 64'd1);

	logic [10:0]          key_q   [NOTE_SLOTS];
	logic [6:0]           vel_q   [NOTE_SLOTS];
	logic [TIME_BITS-1:0] step_q  [NOTE_SLOTS];
	logic [TIME_BITS-1:0] gate_q  [NOTE_SLOTS];
	logic [1:0]           flg_q   [NOTE_SLOTS];
	logic [CW-1:0]        cnt_q, r_q, w_q;
	logic [4:0]           n_q;
	logic [27:0]          delta_q;
	logic                 busy_q, pend_v_q, out_v_q;
	logic [10:0]          pend_key_q;
	logic [6:0]           pend_vel_q;
	logic [TIME_BITS-1:0] pend_step_q, pend_gate_q;

	logic [IW-1:0]        ri, wi, ci;
	logic                 at_end, fin, out_free, do_step, do_flush;
	logic [SW-1:0]        s_sum, g_sum;
	logic [TIME_BITS-1:0] s_new, g_new;

	assign ri = r_q[IW-1:0];
	assign wi = w_q[IW-1:0];
	assign ci = cnt_q[IW-1:0];
	assign at_end = (r_q == cnt_q);
	assign out_free = !out_v_q || out_ready;
	assign fin = (flg_q[ri] == 2'b11) && (n_q < 5'(mtnt_pkg::MAX_OUT));
	assign do_step = busy_q && !at_end && (!fin || !pend_v_q || out_free);
	assign do_flush = busy_q && at_end && pend_v_q && out_free;
	assign s_sum = SW'(step_q[ri]) + SW'(delta_q);
	assign g_sum = SW'(gate_q[ri]) + SW'(delta_q);
	assign s_new = flg_q[ri][0] ? step_q[ri]
		: ((s_sum > LIM) ? {TIME_BITS{1'b1}} : s_sum[TIME_BITS-1:0]);
	assign g_new = flg_q[ri][1] ? gate_q[ri]
		: ((g_sum > LIM) ? {TIME_BITS{1'b1}} : g_sum[TIME_BITS-1:0]);

	assign stat.busy = busy_q;
	assign stat.out_full = out_v_q;
	assign out_valid = out_v_q;

	// table storage; no reset on payload
	always_ff @(posedge clk) begin
		if (cmd.note_on) begin
			for (int i = 0; i < NOTE_SLOTS; i++)
				if (CW'(i) < cnt_q) flg_q[i] <= flg_q[i] | 2'b01;
			if (cnt_q < CW'(NOTE_SLOTS)) begin
				key_q[ci] <= {cmd.ch, cmd.note};
				vel_q[ci] <= cmd.vel;
				step_q[ci] <= '0;
				gate_q[ci] <= '0;
				flg_q[ci] <= 2'b00;
			end
		end
		if (cmd.note_off) begin
			for (int i = 0; i < NOTE_SLOTS; i++)
				if (CW'(i) < cnt_q && key_q[i] == {cmd.ch, cmd.note})
					flg_q[i] <= flg_q[i] | 2'b10;
		end
		if (do_step && !fin) begin
			key_q[wi] <= key_q[ri];
			vel_q[wi] <= vel_q[ri];
			step_q[wi] <= s_new;
			gate_q[wi] <= g_new;
			flg_q[wi] <= flg_q[ri];
		end
		if (do_step && fin) begin
			pend_key_q <= key_q[ri];
			pend_vel_q <= vel_q[ri];
			pend_step_q <= step_q[ri];
			pend_gate_q <= gate_q[ri];
		end
		if (cmd.scan) delta_q <= cmd.delta;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.err) begin
			record_kind <= cmd.err_kind; channel <= '0; note_number <= '0;
			step_time <= '0; gate_time <= '0; velocity <= '0; last_of_run <= 1'b1;
		end else if (cmd.note_on && cnt_q >= CW'(NOTE_SLOTS)) begin
			record_kind <= mtnt_pkg::KIND_OVFL; channel <= cmd.ch;
			note_number <= cmd.note; step_time <= '0; gate_time <= '0;
			velocity <= cmd.vel; last_of_run <= 1'b1;
		end else if ((do_step && fin && pend_v_q) || do_flush) begin
			record_kind <= mtnt_pkg::KIND_NOTE;
			channel <= pend_key_q[10:7];
			note_number <= pend_key_q[6:0];
			step_time <= 32'(pend_step_q);
			gate_time <= 32'(pend_gate_q);
			velocity <= pend_vel_q;
			last_of_run <= do_flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; r_q <= '0; w_q <= '0; n_q <= '0;
			busy_q <= 1'b0; pend_v_q <= 1'b0; out_v_q <= 1'b0;
		end else begin
			if (cmd.clear) cnt_q <= '0;
			if (cmd.note_on && cnt_q < CW'(NOTE_SLOTS)) cnt_q <= cnt_q + 1'b1;
			if (cmd.scan) begin
				busy_q <= 1'b1; r_q <= '0; w_q <= '0; n_q <= '0;
			end
			if (do_step) begin
				r_q <= r_q + 1'b1;
				if (fin) begin
					n_q <= n_q + 5'd1; pend_v_q <= 1'b1;
				end else w_q <= w_q + 1'b1;
			end
			if (do_flush) pend_v_q <= 1'b0;
			if (busy_q && at_end && !pend_v_q) begin
				busy_q <= 1'b0; cnt_q <= w_q;
			end
			if (cmd.err || (cmd.note_on && cnt_q >= CW'(NOTE_SLOTS))
				|| (do_step && fin && pend_v_q) || do_flush)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end
endmodule

FILE: rtl/core/mtnt_checker.sv
// ----------------------------------------------------------------------------
// mtnt_checker
// Port-level checks on the note timer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mtnt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] record_kind,
	input logic       last_of_run
);
	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`CHK_IMPLY(a_no_in_while_out, out_valid, !in_ready)
	`CHK_IMPLY(a_err_last, out_valid && record_kind != mtnt_pkg::KIND_NOTE, last_of_run)
endmodule

bind midi_track_note_timer_top mtnt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .record_kind(record_kind), .last_of_run(last_of_run)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives Standard MIDI File byte streams into the note timer and checks
// every record against a cycle-free predictor of the parser and note table.
// ----------------------------------------------------------------------------
module testbench;
	localparam int SLOTS     = 16;
	localparam int LIMIT     = 600000;
	localparam int TAIL      = SLOTS + 8;

	// parser phases of the predictor
	typedef enum int {
		P_HDR, P_TRK, P_DELTA, P_EVENT, P_DATA1, P_DATA2,
		P_SYSLEN, P_MTYPE, P_MLEN, P_SKIP
	} phase_e;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  ch;
		logic [6:0]  note;
		logic [31:0] step;
		logic [31:0] gate;
		logic [6:0]  vel;
		logic        last;
	} record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  file_byte = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  record_kind;
	logic [3:0]  channel;
	logic [6:0]  note_number;
	logic [31:0] step_time;
	logic [31:0] gate_time;
	logic [6:0]  velocity;
	logic        last_of_run;

	midi_track_note_timer_top u_top (
		.clk(clk), .arst_n(arst_n), .file_byte(file_byte),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.record_kind(record_kind), .channel(channel), .note_number(note_number),
		.step_time(step_time), .gate_time(gate_time), .velocity(velocity),
		.last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	// ---- predictor state: mirrors the parser and the held-note table ----
	phase_e      phase;
	logic [27:0] countdown;
	logic [27:0] accum;
	logic [7:0]  run_status;
	logic [6:0]  data1;
	logic        halted;
	int          held_n;
	logic [10:0] key_tbl [SLOTS];
	logic [6:0]  vel_tbl [SLOTS];
	logic [31:0] step_tbl [SLOTS];
	logic [31:0] gate_tbl [SLOTS];
	logic [1:0]  flag_tbl [SLOTS];

	record_t     pending_records [$];
	int          errors = 0;
	int          bytes_sent = 0;
	int          notes_seen = 0;
	int          ovfl_seen = 0;
	int          faults_seen = 0;
	int          cycles = 0;
	int          burst_left = 0;

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [27:0] d);
		logic [32:0] s;
		s = {1'b0, a} + {5'd0, d};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic record_t make_rec(logic [1:0] k, logic [3:0] c, logic [6:0] n,
			logic [31:0] s, logic [31:0] g, logic [6:0] v);
		record_t r;
		r.kind = k; r.ch = c; r.note = n; r.step = s; r.gate = g; r.vel = v;
		r.last = 1'b0;
		return r;
	endfunction

	// Advance the predictor by one accepted byte and queue what it yields.
	task automatic predict_byte(input logic [7:0] b);
		record_t batch [$];
		logic [27:0] len;
		logic [3:0] hi;
		int w;
		if (halted)
			return;
		case (phase)
			P_HDR: if (countdown <= 1) begin
				phase = P_TRK; countdown = 8; held_n = 0;
			end else countdown--;
			P_TRK: if (countdown <= 1) begin
				phase = P_DELTA; accum = 0;
			end else countdown--;
			P_EVENT: begin
				if (b[7]) begin
					if (b <= 8'hEF) begin
						run_status = b; phase = P_DATA1;
					end else if (b == 8'hFF) begin
						run_status = 0; phase = P_MTYPE;
					end else if (b == 8'hF0 || b == 8'hF7) begin
						run_status = 0; accum = 0; phase = P_SYSLEN;
					end else begin
						batch.push_back(make_rec(mtnt_pkg::KIND_BAD_ST, 0, 0, 0, 0, 0));
						halted = 1'b1;
					end
				end else if (run_status == 0) begin
					batch.push_back(make_rec(mtnt_pkg::KIND_NO_RS, 0, 0, 0, 0, 0));
					halted = 1'b1;
				end else begin
					data1 = b[6:0];
					hi = run_status[7:4];
					phase = (hi == 4'hC || hi == 4'hD) ? P_DELTA : P_DATA2;
				end
			end
			P_DATA1: begin
				data1 = b[6:0];
				hi = run_status[7:4];
				phase = (hi == 4'hC || hi == 4'hD) ? P_DELTA : P_DATA2;
			end
			P_DATA2: begin
				hi = run_status[7:4];
				phase = P_DELTA;
				if (hi == 4'h9 && b[6:0] != 0) begin
					for (int i = 0; i < held_n; i++) flag_tbl[i][0] = 1'b1;
					if (held_n >= SLOTS) begin
						batch.push_back(make_rec(mtnt_pkg::KIND_OVFL, run_status[3:0],
							data1, 0, 0, b[6:0]));
					end else begin
						key_tbl[held_n] = {run_status[3:0], data1};
						vel_tbl[held_n] = b[6:0];
						step_tbl[held_n] = 0;
						gate_tbl[held_n] = 0;
						flag_tbl[held_n] = 2'b00;
						held_n++;
					end
				end else if (hi == 4'h9 || hi == 4'h8) begin
					for (int i = 0; i < held_n; i++)
						if (key_tbl[i] == {run_status[3:0], data1}) flag_tbl[i][1] = 1'b1;
				end
			end
			P_SYSLEN, P_MLEN: begin
				accum = {accum[20:0], b[6:0]};
				if (!b[7]) begin
					len = accum;
					accum = 0;
					if (phase == P_MLEN && data1 == 1 && len == 0) begin
						held_n = 0; countdown = 8; phase = P_TRK;
					end else if (len == 0) phase = P_DELTA;
					else begin
						countdown = len; phase = P_SKIP;
					end
				end
			end
			P_MTYPE: begin
				data1 = (b == 8'h2F) ? 7'd1 : 7'd0;
				accum = 0;
				phase = P_MLEN;
			end
			P_SKIP: if (countdown <= 1) phase = P_DELTA; else countdown--;
			default: begin
				accum = {accum[20:0], b[6:0]};
				if (b[7]) phase = P_DELTA;
				else begin
					// emit finished notes in arrival order, compact the rest
					len = accum;
					accum = 0;
					w = 0;
					for (int r = 0; r < held_n; r++) begin
						if (flag_tbl[r] == 2'b11 && batch.size() < mtnt_pkg::MAX_OUT) begin
							batch.push_back(make_rec(mtnt_pkg::KIND_NOTE, key_tbl[r][10:7],
								key_tbl[r][6:0], step_tbl[r], gate_tbl[r], vel_tbl[r]));
						end else begin
							key_tbl[w] = key_tbl[r]; vel_tbl[w] = vel_tbl[r];
							step_tbl[w] = step_tbl[r]; gate_tbl[w] = gate_tbl[r];
							flag_tbl[w] = flag_tbl[r];
							w++;
						end
					end
					held_n = w;
					for (int r = 0; r < held_n; r++) begin
						if (!flag_tbl[r][0]) step_tbl[r] = sat_sum(step_tbl[r], len);
						if (!flag_tbl[r][1]) gate_tbl[r] = sat_sum(gate_tbl[r], len);
					end
					phase = P_EVENT;
				end
			end
		endcase
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) pending_records.push_back(batch[i]);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
	endtask

	// ---- record checker: compare every output beat with the oldest expectation ----
	always @(posedge clk) begin
		record_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_records.size() == 0) begin
				report("unexpected record", 32'(record_kind), 0);
			end else begin
				want = pending_records.pop_front();
				if (record_kind !== want.kind)
					report("record_kind", 32'(record_kind), 32'(want.kind));
				if (channel !== want.ch) report("channel", 32'(channel), 32'(want.ch));
				if (note_number !== want.note)
					report("note_number", 32'(note_number), 32'(want.note));
				if (step_time !== want.step) report("step_time", step_time, want.step);
				if (gate_time !== want.gate) report("gate_time", gate_time, want.gate);
				if (velocity !== want.vel) report("velocity", 32'(velocity), 32'(want.vel));
				if (last_of_run !== want.last)
					report("last_of_run", 32'(last_of_run), 32'(want.last));
				case (want.kind)
					mtnt_pkg::KIND_NOTE: notes_seen++;
					mtnt_pkg::KIND_OVFL: ovfl_seen++;
					default: faults_seen++;
				endcase
			end
		end
	end

	// Receiver stalls: a fully ready stretch, then random back-pressure.
	always @(negedge clk) begin
		if (cycles % 300 < 60) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// ---- stimulus helpers ----
	// Send one byte: bursts of beats with random idle gaps in between.
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		file_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic send_vlq(input logic [27:0] v);
		logic [6:0] grp [4];
		int top;
		for (int i = 0; i < 4; i++) grp[i] = v[7 * i +: 7];
		top = 0;
		for (int i = 1; i < 4; i++) if (grp[i] != 0) top = i;
		for (int i = top; i >= 0; i--) send_byte({(i != 0), grp[i]});
	endtask

	task automatic send_headers(input bit with_file_hdr);
		if (with_file_hdr)
			for (int i = 0; i < 14; i++) send_byte(8'($urandom_range(0, 255)));
		for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_note(input logic [3:0] st_hi, input logic [3:0] ch,
			input logic [6:0] n, input logic [6:0] v, input bit running);
		if (!running) send_byte({st_hi, ch});
		send_byte({1'b0, n});
		send_byte({1'b0, v});
	endtask

	task automatic send_track_end();
		send_vlq(0);
		send_byte(8'hFF); send_byte(8'h2F); send_byte(8'h00);
		send_headers(1'b0);
	endtask

	// Hold input until every expected record has come, then let the scan settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_records.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	// ---- tests ----
	task automatic test_basic_notes();
		send_headers(1'b1);
		send_vlq(0);  send_note(4'h9, 4'h0, 7'd60, 7'd100, 0);
		send_vlq(96); send_note(4'h9, 4'h0, 7'd64, 7'd127, 1);   // running status
		send_vlq(10); send_note(4'h8, 4'h0, 7'd60, 7'd0, 0);
		send_vlq(5);  send_note(4'h9, 4'hF, 7'd127, 7'd1, 0);
		send_vlq(0);  send_note(4'h9, 4'h0, 7'd64, 7'd0, 0);     // velocity zero releases
		send_vlq(3);  send_note(4'h8, 4'hF, 7'd127, 7'd0, 0);
		send_vlq(1);  send_note(4'h9, 4'h1, 7'd0, 7'd1, 0);
		send_vlq(0);  send_note(4'h8, 4'h1, 7'd0, 7'd0, 0);
		send_vlq(28'h0FFF_FFFF);
	endtask

	task automatic test_other_statuses();
		send_byte(8'hA3); send_byte(8'hC5); send_byte(8'h7F);      // top bit of data ignored
		send_vlq(0); send_byte(8'hB2); send_byte(8'h07); send_byte(8'h40);
		send_vlq(0); send_byte(8'hC4); send_byte(8'h11);
		send_vlq(0); send_byte(8'hD6); send_byte(8'h22);
		send_vlq(0); send_byte(8'hE1); send_byte(8'h00); send_byte(8'h40);
		send_vlq(0); send_byte(8'hF0); send_vlq(3);
		send_byte(8'h01); send_byte(8'h02); send_byte(8'hF7);
		send_vlq(0); send_byte(8'hF7); send_vlq(0);
		send_vlq(0); send_byte(8'hFF); send_byte(8'h2F); send_vlq(2);  // not a track end
		send_byte(8'hAA); send_byte(8'h55);
		send_vlq(0); send_byte(8'hFF); send_byte(8'h51);
		send_byte(8'h80); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
		send_byte(8'h00);                                           // five-byte length wraps
		send_vlq(0); send_note(4'h9, 4'h2, 7'd40, 7'd50, 0);
		send_track_end();                                           // discards held note
	endtask

	task automatic test_overflow();
		send_vlq(0); send_byte(8'h93);
		for (int i = 0; i < SLOTS + 1; i++) begin
			send_byte(8'(i)); send_byte(8'(i + 1));
			send_vlq(0);
		end
		send_note(4'h8, 4'h3, 7'd0, 7'd0, 0);
		for (int i = 1; i < SLOTS; i++) begin
			send_vlq(0); send_note(4'h8, 4'h3, 7'(i), 7'd0, 1);
		end
		send_vlq(2);                                                // full run of records
		drain();
	endtask

	task automatic test_saturation();
		send_byte(8'h9A); send_byte(8'h30); send_byte(8'h60);
		for (int i = 0; i < 17; i++) begin
			send_vlq(28'h0FFF_FFFF);
			send_byte(8'hDA); send_byte(8'h00);
		end
		send_vlq(0); send_note(4'h9, 4'hA, 7'd31, 7'd9, 0);
		send_vlq(0); send_note(4'h8, 4'hA, 7'd48, 7'd0, 0);
		send_vlq(0); send_note(4'h8, 4'hA, 7'd31, 7'd0, 1);
		send_vlq(1);
		drain();                                                    // sender pause
	endtask

	task automatic test_random_tracks();
		int target;
		logic [3:0] ch;
		logic [6:0] n;
		target = bytes_sent + 50;
		while (bytes_sent < target) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					ch = 4'($urandom_range(0, 3)); n = 7'd60 + 7'($urandom_range(0, 5));
					send_note(4'h9, ch, n, 7'($urandom_range(1, 127)), 0);
				end
				8, 9, 10, 11, 12: begin
					ch = 4'($urandom_range(0, 3)); n = 7'd60 + 7'($urandom_range(0, 5));
					send_note($urandom_range(0, 1) ? 4'h8 : 4'h9, ch, n, 0, 0);
				end
				13: send_note(4'h8 + 4'($urandom_range(2, 6)), 4'($urandom_range(0, 15)),
					7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 0);
				14: begin
					send_byte($urandom_range(0, 1) ? 8'hF0 : 8'hF7);
					send_vlq(28'($urandom_range(0, 3)));
					while (phase == P_SKIP) send_byte(8'($urandom_range(0, 255)));
				end
				15: begin
					send_byte(8'hFF); send_byte(8'($urandom_range(0, 127)));
					send_vlq(28'($urandom_range(0, 3)));
					while (phase == P_SKIP || phase == P_TRK)
						send_byte(8'($urandom_range(0, 255)));
				end
				16: begin
					send_byte(8'hFF); send_byte(8'h2F); send_byte(8'h00);
					send_headers(1'b0);
				end
				default: begin
					// data byte with its top bit set, under a fresh status
					send_byte({4'h9, 4'($urandom_range(0, 15))});
					send_byte({1'b1, 7'($urandom_range(0, 127))});
					send_byte({1'b1, 7'($urandom_range(0, 127))});
				end
			endcase
			if (phase == P_DELTA)
				send_vlq($urandom_range(0, 3) == 0 ? 28'($urandom_range(0, 28'h0FFF_FFFF))
					: 28'($urandom_range(0, 200)));
		end
		drain();
	endtask

	// Errors halt the block until reset, so only one is taken per run.
	task automatic test_halt();
		if (phase != P_EVENT) send_vlq(0);
		if ($urandom_range(0, 1)) begin
			send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00);
			send_vlq(0);
			send_byte(8'($urandom_range(0, 127)));
		end else begin
			send_byte($urandom_range(0, 1) ? 8'(8'hF0 + $urandom_range(1, 6))
				: 8'(8'hF8 + $urandom_range(0, 6)));
		end
		for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		phase = P_HDR; countdown = 14; accum = 0; run_status = 0; data1 = 0;
		halted = 1'b0; held_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_basic_notes();
		test_other_statuses();
		test_overflow();
		test_saturation();
		test_random_tracks();
		test_halt();

		drain();
		$display("covered %0d file bytes: %0d note records, %0d overflow records,",
			bytes_sent, notes_seen, ovfl_seen);
		$display("%0d halting error record(s), %0d mismatches", faults_seen, errors);
		if (errors == 0 && pending_records.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mtnt_pkg.sv
rtl/core/mtnt_ctrl.sv
rtl/core/mtnt_dpath.sv
rtl/core/midi_track_note_timer_top.sv
rtl/core/mtnt_checker.sv
tb/testbench.sv
